[sv/range_sweep_obstacle_segmenter_unit_assert.svh]
// Assertion macros for the range sweep obstacle segmenter.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef RANGE_SWEEP_OBSTACLE_SEGMENTER_UNIT_ASSERT_SVH
`define RANGE_SWEEP_OBSTACLE_SEGMENTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, quiet while in reset.
`define RSOS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising edge, quiet while in reset.
`define RSOS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rsos_pkg.sv]
// Shared types and constants for the range sweep obstacle segmenter.
// No dependencies; used by the core, the result queue and the top level.
package rsos_pkg;

	localparam int unsigned ANGLE_W = 8;
	localparam int unsigned IR_W    = 12;
	localparam int unsigned SUM_W   = 14;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned CFG_W   = 12;

	localparam logic [11:0] EDGE_THRESHOLD_RST    = 12'd100;
	localparam logic [7:0]  MIN_SPAN_RST          = 8'd10;
	localparam logic [11:0] INITIAL_REFERENCE_RST = 12'd610;

	typedef enum logic [1:0] {
		REG_EDGE_THRESHOLD    = 2'd0,
		REG_MIN_SPAN          = 2'd1,
		REG_INITIAL_REFERENCE = 2'd2
	} rsos_reg_t;

	localparam logic MODE_SCAN = 1'b0;
	localparam logic MODE_STOP = 1'b1;
	localparam logic KIND_RECORD  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic                   valid;
		logic [1:0]             index;
		logic [CFG_W-1:0]       data;
	} rsos_cfg_wr_t;

	typedef struct packed {
		logic                   kind;
		logic [IDX_W-1:0]       obstacle_index;
		logic [ANGLE_W-1:0]     start_angle;
		logic [ANGLE_W-1:0]     end_angle;
		logic [ANGLE_W-1:0]     span_degrees;
		logic [ANGLE_W-1:0]     center_angle;
		logic                   rejected;
		logic                   found;
		logic                   last;
	} rsos_rec_t;

	typedef struct packed {
		logic [1:0]             level;
		logic                   in_ready;
		logic                   pop;
	} rsos_qstat_t;

endpackage

[sv/range_sweep_obstacle_segmenter_unit.sv]
// Top level of the range sweep obstacle segmenter: stream ports and config channel.
// Depends on rsos_pkg, rsos_core, rsos_outq and the assertion macro header.
//
// Use:
//   Scan samples and end-of-sweep words enter on the s_ side; s_tuser is the mode
//   (0 scan, 1 end of sweep). Obstacle records and sweep summaries leave on the m_
//   side; m_tuser is the kind (0 record, 1 summary) and m_tlast marks the final
//   result of the input word that caused it.
//   Results: each result is registered in the result queue and leaves on m_ in order.
//   Throughput: one input word per cycle while results drain; an end-of-sweep
//   word that force-closes an obstacle yields two results, which leave one after
//   the other. The three-word result queue sets this: s_tready stays
//   high while at least two slots will be free after this cycle's output.
//   Stall: with m_tready low the queue holds its words; s_tready drops once a
//   further input could overflow it, so nothing is lost.
//   Reset: arst_n clears the queue and sweep state and loads the register
//   defaults (threshold 100, minimum span 10, reference 610).
//   Config: cfg_valid with cfg_index/cfg_data writes one register; cfg_ready is
//   always high. Write only while the block is idle.
`include "range_sweep_obstacle_segmenter_unit_assert.svh"

module range_sweep_obstacle_segmenter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // angle[7:0], ir_first[19:8], ir_second[31:20],
	                               // ir_third[43:32], zero pad[47:44]
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // obstacle_index[5:0], start_angle[13:6],
	                               // end_angle[21:14], span_degrees[29:22],
	                               // center_angle[37:30], rejected[38], found[39]
	output logic        m_tuser,   // kind
	output logic        m_tlast    // last
);

	rsos_pkg::rsos_cfg_wr_t cfg_wr;
	rsos_pkg::rsos_rec_t    rec_a, rec_b, head;
	rsos_pkg::rsos_qstat_t  qstat;
	logic [1:0]             push_n;
	logic                   in_fire;

	// Register writes never stall
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	assign s_tready = qstat.in_ready;
	assign in_fire  = s_tvalid && s_tready;

	rsos_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.in_fire   (in_fire),
		.mode      (s_tuser),
		.angle     (s_tdata[7:0]),
		.ir_first  (s_tdata[19:8]),
		.ir_second (s_tdata[31:20]),
		.ir_third  (s_tdata[43:32]),
		.push_n    (push_n),
		.rec_a     (rec_a),
		.rec_b     (rec_b)
	);

	rsos_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.rec_a     (rec_a),
		.rec_b     (rec_b),
		.out_ready (m_tready),
		.head      (head),
		.out_valid (m_tvalid),
		.stat      (qstat)
	);

	// Pack the head word onto the output bus, first field lowest
	assign m_tdata = {head.found, head.rejected, head.center_angle, head.span_degrees,
		head.end_angle, head.start_angle, head.obstacle_index};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	// Accepting a word must leave room for both of its possible results
	`RSOS_ASSERT_NOW(a_queue_room, in_fire,
		(qstat.level == 2'd0) || (qstat.level == 2'd1) || (qstat.pop && qstat.level == 2'd2),
		"result queue could overflow")
	// A sweep summary always closes its input word
	`RSOS_ASSERT_NOW(a_summary_last, m_tvalid && m_tuser, m_tlast,
		"summary without last")
	// A forced-close record is followed straight away by its summary
	`RSOS_ASSERT_NEXT(a_close_then_summary, m_tvalid && m_tready && !m_tuser && !m_tlast,
		m_tvalid && m_tuser, "forced close not followed by summary")
	// An accepted end-of-sweep word always leaves a summary queued
	`RSOS_ASSERT_NEXT(a_stop_queued, in_fire && s_tuser == rsos_pkg::MODE_STOP,
		qstat.level != 2'd0, "end of sweep produced no result")

endmodule

[sv/rsos_core.sv]
// Segmenter core: configuration registers, sweep state and result generation.
// Depends on rsos_pkg.
module rsos_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rsos_pkg::rsos_cfg_wr_t               cfg_wr,
	input  logic                                 in_fire,
	input  logic                                 mode,
	input  logic [rsos_pkg::ANGLE_W-1:0]         angle,
	input  logic [rsos_pkg::IR_W-1:0]            ir_first,
	input  logic [rsos_pkg::IR_W-1:0]            ir_second,
	input  logic [rsos_pkg::IR_W-1:0]            ir_third,
	output logic [1:0]                           push_n,
	output rsos_pkg::rsos_rec_t                  rec_a,
	output rsos_pkg::rsos_rec_t                  rec_b
);

	logic [11:0] edge_threshold_q;
	logic [7:0]  min_span_q;
	logic [11:0] initial_ref_q;

	logic [rsos_pkg::SUM_W-1:0]   prev_sum_q;
	logic                         fresh_q;
	logic                         open_q;
	logic [rsos_pkg::ANGLE_W-1:0] start_q;
	logic [rsos_pkg::IDX_W-1:0]   kept_q;
	logic [rsos_pkg::ANGLE_W-1:0] best_span_q;
	logic [rsos_pkg::ANGLE_W-1:0] best_center_q;
	logic [rsos_pkg::IDX_W-1:0]   best_index_q;
	logic                         best_valid_q;

	logic [rsos_pkg::SUM_W-1:0]   sum, ref3, prev, thr;
	logic                         prev_nz, rise, fall, do_close, rej, upd;
	logic                         open_mid;
	logic [rsos_pkg::ANGLE_W-1:0] start_mid, span, center;
	logic [rsos_pkg::IDX_W-1:0]   kept_mid, kept_after, idx;
	logic [rsos_pkg::ANGLE_W-1:0] best_span_mid, best_center_mid;
	logic [rsos_pkg::IDX_W-1:0]   best_index_mid;
	logic                         best_valid_mid;
	rsos_pkg::rsos_rec_t          close_rec, summary_rec;

	always_comb begin
		sum = rsos_pkg::SUM_W'(ir_first) + rsos_pkg::SUM_W'(ir_second)
			+ rsos_pkg::SUM_W'(ir_third);
		ref3 = {1'b0, initial_ref_q, 1'b0} + {2'b00, initial_ref_q};
		thr  = {1'b0, edge_threshold_q, 1'b0} + {2'b00, edge_threshold_q};
		prev = fresh_q ? ref3 : prev_sum_q;
		prev_nz = (prev != '0);

		rise = (mode == rsos_pkg::MODE_SCAN) && !open_q && prev_nz && (sum > prev)
			&& ((sum - prev) > thr);
		fall = prev_nz && (prev > sum) && ((prev - sum) > thr);

		open_mid  = open_q | rise;
		start_mid = rise ? angle : start_q;
		kept_mid  = rise ? kept_q + 1'b1 : kept_q;

		do_close = (mode == rsos_pkg::MODE_STOP) ? open_q : (open_mid && fall);

		idx    = kept_mid - 1'b1;
		span   = (angle >= start_mid) ? angle - start_mid : '0;
		center = start_mid + {1'b0, span[7:1]};
		rej    = span < min_span_q;

		kept_after = (do_close && rej) ? kept_mid - 1'b1 : kept_mid;

		// Narrowest kept obstacle: first one with a strictly smaller span wins
		upd = do_close && !rej && (!best_valid_q || span < best_span_q);
		best_valid_mid  = best_valid_q | upd;
		best_span_mid   = upd ? span   : best_span_q;
		best_center_mid = upd ? center : best_center_q;
		best_index_mid  = upd ? idx    : best_index_q;

		close_rec.kind           = rsos_pkg::KIND_RECORD;
		close_rec.obstacle_index = idx;
		close_rec.start_angle    = start_mid;
		close_rec.end_angle      = angle;
		close_rec.span_degrees   = span;
		close_rec.center_angle   = center;
		close_rec.rejected       = rej;
		close_rec.found          = 1'b0;
		close_rec.last           = (mode == rsos_pkg::MODE_SCAN);

		summary_rec.kind           = rsos_pkg::KIND_SUMMARY;
		summary_rec.obstacle_index = best_valid_mid ? best_index_mid : '0;
		summary_rec.start_angle    = '0;
		summary_rec.end_angle      = '0;
		summary_rec.span_degrees   = best_valid_mid ? best_span_mid : '0;
		summary_rec.center_angle   = best_valid_mid ? best_center_mid : '0;
		summary_rec.rejected       = 1'b0;
		summary_rec.found          = best_valid_mid;
		summary_rec.last           = 1'b1;

		rec_a = (mode == rsos_pkg::MODE_STOP && !do_close) ? summary_rec : close_rec;
		rec_b = summary_rec;

		if (!in_fire) begin
			push_n = 2'd0;
		end else if (mode == rsos_pkg::MODE_STOP) begin
			push_n = do_close ? 2'd2 : 2'd1;
		end else begin
			push_n = {1'b0, do_close};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_threshold_q <= rsos_pkg::EDGE_THRESHOLD_RST;
			min_span_q       <= rsos_pkg::MIN_SPAN_RST;
			initial_ref_q    <= rsos_pkg::INITIAL_REFERENCE_RST;
		end else if (cfg_wr.valid) begin
			case (rsos_pkg::rsos_reg_t'(cfg_wr.index))
				rsos_pkg::REG_EDGE_THRESHOLD:    edge_threshold_q <= cfg_wr.data;
				rsos_pkg::REG_MIN_SPAN:          min_span_q <= cfg_wr.data[7:0];
				rsos_pkg::REG_INITIAL_REFERENCE: initial_ref_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sum_q    <= rsos_pkg::SUM_W'(3 * rsos_pkg::INITIAL_REFERENCE_RST);
			fresh_q       <= 1'b1;
			open_q        <= 1'b0;
			start_q       <= '0;
			kept_q        <= '0;
			best_span_q   <= '0;
			best_center_q <= '0;
			best_index_q  <= '0;
			best_valid_q  <= 1'b0;
		end else if (in_fire) begin
			if (mode == rsos_pkg::MODE_STOP) begin
				prev_sum_q    <= ref3;
				fresh_q       <= 1'b1;
				open_q        <= 1'b0;
				start_q       <= '0;
				kept_q        <= '0;
				best_span_q   <= '0;
				best_center_q <= '0;
				best_index_q  <= '0;
				best_valid_q  <= 1'b0;
			end else begin
				prev_sum_q    <= sum;
				fresh_q       <= 1'b0;
				open_q        <= open_mid & ~do_close;
				start_q       <= start_mid;
				kept_q        <= kept_after;
				best_span_q   <= best_span_mid;
				best_center_q <= best_center_mid;
				best_index_q  <= best_index_mid;
				best_valid_q  <= best_valid_mid;
			end
		end
	end

endmodule

[sv/rsos_outq.sv]
// Three-word result queue: slot 0 drives the output channel, up to two pushes a cycle.
// Depends on rsos_pkg.
module rsos_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_n,
	input  rsos_pkg::rsos_rec_t  rec_a,
	input  rsos_pkg::rsos_rec_t  rec_b,
	input  logic                 out_ready,
	output rsos_pkg::rsos_rec_t  head,
	output logic                 out_valid,
	output rsos_pkg::rsos_qstat_t stat
);

	rsos_pkg::rsos_rec_t slot_q [3];
	rsos_pkg::rsos_rec_t slot_n [3];
	logic [1:0] level_q, level_p;
	logic       pop;

	always_comb begin
		pop     = (level_q != 2'd0) && out_ready;
		level_p = level_q - {1'b0, pop};
		for (int i = 0; i < 3; i++) begin
			slot_n[i] = (pop && i < 2) ? slot_q[(i < 2) ? i + 1 : i] : slot_q[i];
			if (push_n != 2'd0 && 2'(i) == level_p) begin
				slot_n[i] = rec_a;
			end
			if (push_n == 2'd2 && 2'(i) == level_p + 2'd1) begin
				slot_n[i] = rec_b;
			end
		end
		stat.level    = level_q;
		stat.in_ready = (level_p <= 2'd1);
		stat.pop      = pop;
		head          = slot_q[0];
		out_valid     = (level_q != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 2'd0;
		end else begin
			level_q <= level_p + push_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			slot_q[i] <= slot_n[i];
		end
	end

endmodule
